### design/lsr_pkg.sv
// shared types and codes for the lifo stack with reverse
package lsr_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_REVERSE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PEEK   = 6'b000010,
        ST_SW_RD  = 6'b000100,
        ST_SW_WLO = 6'b001000,
        ST_SW_WHI = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    localparam int unsigned FIELD_BITS = 32;
    localparam int unsigned COUNT_BITS = 7;

endpackage

### design/lifo_stack_with_reverse.sv
// top level: bounded lifo stack with push, pop, peek and in-place reverse
//
// channel   dir  signals                      contents
// s         in   s_tvalid s_tready s_tdata    push_value, command in s_tuser
//                s_tuser
// m         out  m_tvalid m_tready m_tdata    top_value, entry_count, status and
//                m_tuser                      empty_flag in m_tuser
//
// push and pop answer directly; peek passes through ST_PEEK (registered ram read)
// reverse runs ST_SW_RD, ST_SW_WLO, ST_SW_WHI per swap, then ST_DONE; one ram read
// and two ram writes per swap, the writes through the single write port
// input is taken only while the sequencer is idle and the output register is free
// rst_n clears the count, sequencer and output valid; stored words are not cleared
module lifo_stack_with_reverse
    import lsr_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] top_value, [38:32] entry_count, [39] zero
    output logic [2:0]  m_tuser    // [1:0] status, [2] empty_flag
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > COUNT_BITS) ? CW : COUNT_BITS;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        lo_reg, lo_next;
    logic [AW-1:0]        hi_reg, hi_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          out_top_reg;
    status_t              out_status_reg;
    logic                 out_empty_reg;
    logic [6:0]           out_count_reg;

    logic                 accept;
    logic                 out_free;
    logic                 load;
    logic [31:0]          load_top;
    status_t              load_status;
    cmd_t                 cmd;
    logic [XW-1:0]        count_ext;
    logic [63:0]          push_ext;
    logic [63:0]          rd_ext;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr_a;
    logic [WORD_BITS-1:0] ram_rdata_a;
    logic [WORD_BITS-1:0] ram_rdata_b;

    lsr_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (hi_next),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    assign cmd      = cmd_t'(s_tuser);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign push_ext = {32'b0, s_tdata};
    assign rd_ext   = 64'(ram_rdata_a);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        load        = 1'b0;
        load_top    = '0;
        load_status = STAT_OK;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[AW-1:0];
        ram_wdata   = push_ext[WORD_BITS-1:0];
        ram_re      = 1'b0;
        ram_raddr_a = lo_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_PUSH:
                        begin
                            load = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                load_status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP:
                        begin
                            load = 1'b1;
                            if (count_reg == '0)
                            begin
                                load_status = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                load        = 1'b1;
                                load_status = STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                ram_raddr_a = AW'(count_reg - 1'b1);
                                state_next  = ST_PEEK;
                            end
                        end
                        CMD_REVERSE:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                load = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = AW'(count_reg - 1'b1);
                                state_next = ST_SW_RD;
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_PEEK:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_top   = rd_ext[31:0];
                    state_next = ST_IDLE;
                end
            end
            ST_SW_RD:
            begin
                ram_re      = 1'b1;
                ram_raddr_a = lo_reg;
                state_next  = ST_SW_WLO;
            end
            ST_SW_WLO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg;
                ram_wdata  = ram_rdata_b;
                state_next = ST_SW_WHI;
            end
            ST_SW_WHI:
            begin
                ram_we    = 1'b1;
                ram_waddr = hi_reg;
                ram_wdata = ram_rdata_a;
                lo_next   = lo_reg + 1'b1;
                hi_next   = hi_reg - 1'b1;
                if ((lo_reg + 1'b1) < (hi_reg - 1'b1))
                begin
                    state_next = ST_SW_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_ext = XW'(count_next);

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_top_reg    <= load_top;
            out_status_reg <= load_status;
            out_empty_reg  <= (count_next == '0);
            out_count_reg  <= count_ext[6:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_top_reg};
    assign m_tuser  = {out_empty_reg, out_status_reg};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SW_RD) |-> (lo_reg < hi_reg))
        else $error("swap pointers crossed");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_PUSH) && (count_reg != CW'(DEPTH)))
            |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow count");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STAT_OVERFLOW)) |-> (count_reg == CW'(DEPTH)))
        else $error("overflow reported below depth");
`endif

endmodule

### design/lsr_ram.sv
// stack storage: one write port, two registered read ports
module lsr_ram #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WORD_BITS-1:0]     wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WORD_BITS-1:0]     rdata_a,
    output logic [WORD_BITS-1:0]     rdata_b
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### bench/lifo_stack_with_reverse_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the lifo stack: random push/pop/peek/reverse traffic checked per reply
module lifo_stack_with_reverse_tb;
    import lsr_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ITEM_TARGET = 1600;
    localparam int CALM_FROM   = 1400;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [31:0] top_value;
        status_t     status;
        logic        empty_flag;
        logic [6:0]  entry_count;
    } stack_reply_t;

    class stack_tracker;
        logic [31:0]  words [DEPTH];
        int unsigned  fill;
        stack_reply_t expected_replies [$];
        int unsigned  errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 30)
                $display("mismatch at %0t: %s", $time, msg);
        endtask

        function stack_reply_t predict_reply(cmd_t cmd, logic [31:0] value);
            stack_reply_t r;
            logic [31:0]  swap;
            int           lo;
            int           hi;
            r.top_value = '0;
            r.status    = STAT_OK;
            case (cmd)
                CMD_PUSH:
                begin
                    if (fill >= DEPTH)
                        r.status = STAT_OVERFLOW;
                    else
                    begin
                        words[fill] = value;
                        fill++;
                    end
                end
                CMD_POP:
                begin
                    if (fill == 0)
                        r.status = STAT_UNDERFLOW;
                    else
                        fill--;
                end
                CMD_PEEK:
                begin
                    if (fill == 0)
                        r.status = STAT_UNDERFLOW;
                    else
                        r.top_value = words[fill - 1];
                end
                default:
                begin
                    lo = 0;
                    hi = int'(fill) - 1;
                    while (lo < hi)
                    begin
                        swap      = words[lo];
                        words[lo] = words[hi];
                        words[hi] = swap;
                        lo++;
                        hi--;
                    end
                end
            endcase
            r.empty_flag  = (fill == 0);
            r.entry_count = fill[6:0];
            return r;
        endfunction

        function void note_input(cmd_t cmd, logic [31:0] value);
            expected_replies.push_back(predict_reply(cmd, value));
        endfunction

        task check_reply(logic [31:0] top_value, logic [6:0] entry_count,
                         logic [1:0] status, logic empty_flag);
            stack_reply_t e;
            if (expected_replies.size() == 0)
            begin
                report("reply with no transaction outstanding");
                return;
            end
            e = expected_replies.pop_front();
            if (top_value !== e.top_value)
                report($sformatf("top_value %h, expected %h", top_value, e.top_value));
            if (status !== e.status)
                report($sformatf("status %0d, expected %0d", status, e.status));
            if (empty_flag !== e.empty_flag)
                report($sformatf("empty_flag %b, expected %b", empty_flag, e.empty_flag));
            if (entry_count !== e.entry_count)
                report($sformatf("entry_count %0d, expected %0d", entry_count,
                                 e.entry_count));
        endtask

        function int unsigned outstanding();
            return expected_replies.size();
        endfunction

        task flush_leftovers();
            while (expected_replies.size() != 0)
            begin
                void'(expected_replies.pop_front());
                report("expected reply never arrived");
            end
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    stack_tracker tracker = new();
    int           cycle_count = 0;
    int           gap_odds    = 0;
    int           stall_odds  = 0;
    int           stall_left  = 0;
    bit           calm        = 1'b0;

    lifo_stack_with_reverse #(
        .DEPTH     (DEPTH),
        .WORD_BITS (32)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // transaction monitor on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.note_input(cmd_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_reply(m_tdata[31:0], m_tdata[38:32], m_tuser[1:0], m_tuser[2]);
        end
    end

    // downstream backpressure in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (!calm && stall_odds != 0 && $urandom_range(1, 100) <= stall_odds)
        begin
            m_tready   <= 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
        end
        else
            m_tready <= 1'b1;
    end

    task send_item(cmd_t cmd, logic [31:0] value);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task idle_sender(int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
    endtask

    function cmd_t pick_command(int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0: return (r < 80) ? CMD_PUSH : (r < 87) ? CMD_POP : (r < 95) ? CMD_PEEK : CMD_REVERSE;
            1: return (r < 15) ? CMD_PUSH : (r < 75) ? CMD_POP : (r < 92) ? CMD_PEEK : CMD_REVERSE;
            default:
                return (r < 35) ? CMD_PUSH : (r < 65) ? CMD_POP : (r < 85) ? CMD_PEEK : CMD_REVERSE;
        endcase
    endfunction

    function logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int  sent;
        int  phase_len;
        int  mode;
        bit  paused;
        sent   = 0;
        paused = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner cases: empty stack, single word, extreme words
        send_item(CMD_PEEK, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_REVERSE, $urandom);
        send_item(CMD_PUSH, 32'h7fff_ffff);
        send_item(CMD_REVERSE, $urandom);
        send_item(CMD_PEEK, $urandom);
        send_item(CMD_PUSH, 32'h8000_0000);
        send_item(CMD_PUSH, 32'h0000_0000);
        send_item(CMD_PUSH, 32'hffff_ffff);
        send_item(CMD_PUSH, 32'h0000_0001);
        send_item(CMD_PEEK, $urandom);
        send_item(CMD_REVERSE, $urandom);
        send_item(CMD_PEEK, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_PEEK, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_PEEK, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_POP, $urandom);
        send_item(CMD_PEEK, $urandom);
        wait_drained();

        while (sent < ITEM_TARGET)
        begin
            mode      = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0:       gap_odds = 0;
                1:       gap_odds = 5;
                default: gap_odds = 20;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_odds = 0;
                1:       stall_odds = 5;
                default: stall_odds = 20;
            endcase
            if (!paused && sent >= ITEM_TARGET / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            repeat (phase_len)
            begin
                if (sent >= CALM_FROM)
                begin
                    calm     = 1'b1;
                    gap_odds = 0;
                end
                send_item(pick_command(mode), pick_value());
                sent++;
                if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds)
                    idle_sender($urandom_range(1, 15));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        tracker.flush_leftovers();

        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### sim.f
design/lsr_pkg.sv
design/lsr_ram.sv
design/lifo_stack_with_reverse.sv
bench/lifo_stack_with_reverse_tb.sv
